[hdl/sic_pkg.sv]
package sic_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int MAG_W  = DET_W - 1;
  localparam int POS_W  = FRAC_BITS + 1;

  // pipeline stage positions
  localparam int ST_DIFF  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_DET   = 2;
  localparam int ST_NORM  = 3;
  localparam int ST_CLASS = 4;
  localparam int ST_OUT   = ST_CLASS + FRAC_BITS + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_CROSS    = 2'd1,
    KIND_TOUCH    = 2'd2,
    KIND_PARALLEL = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] bx;
    logic signed [DIFF_W-1:0] by;
    logic signed [DIFF_W-1:0] cx;
    logic signed [DIFF_W-1:0] cy;
  } diff_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] d1;
    logic signed [PROD_W-1:0] d2;
    logic signed [PROD_W-1:0] l1;
    logic signed [PROD_W-1:0] l2;
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
  } prod_t;

  typedef struct packed {
    logic signed [DET_W-1:0] d;
    logic signed [DET_W-1:0] ln;
    logic signed [DET_W-1:0] mn;
  } det_t;

  typedef struct packed {
    kind_t                kind;
    logic                 sat;
    logic [MAG_W-1:0]     den;
    logic [MAG_W-1:0]     rem;
    logic [FRAC_BITS-1:0] quo;
  } div_t;

endpackage

[hdl/segment_intersection_classifier_unit.sv]
// FRAC_BITS + 6 register stages
// throughput: one beat per cycle while out_stall is low; the restoring divider retires one quotient
// bit per stage, so its FRAC_BITS stages set the depth
// each stage holds while the next is full and stalled; empty stages fill in
// reset (rst_n low, synchronous) empties every stage; payload is not cleared
module segment_intersection_classifier_unit
  import sic_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_first_start_x,
  input  logic signed [COORD_BITS-1:0] in_first_start_y,
  input  logic signed [COORD_BITS-1:0] in_first_end_x,
  input  logic signed [COORD_BITS-1:0] in_first_end_y,
  input  logic signed [COORD_BITS-1:0] in_second_start_x,
  input  logic signed [COORD_BITS-1:0] in_second_start_y,
  input  logic signed [COORD_BITS-1:0] in_second_end_x,
  input  logic signed [COORD_BITS-1:0] in_second_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [POS_W-1:0]             out_position
);

  localparam logic [POS_W-1:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [NUM_ST-1:0] vld_r;
  logic [NUM_ST-1:0] rdy;

  diff_t diff_r, diff_nxt;
  prod_t prod_r, prod_nxt;
  det_t  det_r, det_nxt;
  det_t  norm_r, norm_nxt;
  div_t  div_r   [0:FRAC_BITS];
  div_t  div_nxt [0:FRAC_BITS];
  kind_t            kind_r, kind_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic dz, in_rng, on_edge, pos_ok;
  logic [MAG_W:0] r2   [1:FRAC_BITS];
  logic           ge   [1:FRAC_BITS];

  // a stage moves on when it is empty or the stage after it moves
  always_comb begin
    rdy[NUM_ST-1] = !vld_r[NUM_ST-1] || !out_stall;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[ST_DIFF];

  // edge vectors
  always_comb begin
    diff_nxt.ax = $signed({in_first_end_x[COORD_BITS-1], in_first_end_x})
                - $signed({in_first_start_x[COORD_BITS-1], in_first_start_x});
    diff_nxt.ay = $signed({in_first_end_y[COORD_BITS-1], in_first_end_y})
                - $signed({in_first_start_y[COORD_BITS-1], in_first_start_y});
    diff_nxt.bx = $signed({in_second_end_x[COORD_BITS-1], in_second_end_x})
                - $signed({in_second_start_x[COORD_BITS-1], in_second_start_x});
    diff_nxt.by = $signed({in_second_end_y[COORD_BITS-1], in_second_end_y})
                - $signed({in_second_start_y[COORD_BITS-1], in_second_start_y});
    diff_nxt.cx = $signed({in_first_start_x[COORD_BITS-1], in_first_start_x})
                - $signed({in_second_start_x[COORD_BITS-1], in_second_start_x});
    diff_nxt.cy = $signed({in_first_start_y[COORD_BITS-1], in_first_start_y})
                - $signed({in_second_start_y[COORD_BITS-1], in_second_start_y});
  end

  // cross products
  always_comb begin
    prod_nxt.d1 = $signed(diff_r.ax) * $signed(diff_r.by);
    prod_nxt.d2 = $signed(diff_r.ay) * $signed(diff_r.bx);
    prod_nxt.l1 = $signed(diff_r.cy) * $signed(diff_r.bx);
    prod_nxt.l2 = $signed(diff_r.cx) * $signed(diff_r.by);
    prod_nxt.m1 = $signed(diff_r.cy) * $signed(diff_r.ax);
    prod_nxt.m2 = $signed(diff_r.cx) * $signed(diff_r.ay);
  end

  // determinant and numerators
  always_comb begin
    det_nxt.d  = $signed({prod_r.d1[PROD_W-1], prod_r.d1})
               - $signed({prod_r.d2[PROD_W-1], prod_r.d2});
    det_nxt.ln = $signed({prod_r.l1[PROD_W-1], prod_r.l1})
               - $signed({prod_r.l2[PROD_W-1], prod_r.l2});
    det_nxt.mn = $signed({prod_r.m1[PROD_W-1], prod_r.m1})
               - $signed({prod_r.m2[PROD_W-1], prod_r.m2});
  end

  // make the determinant non-negative
  always_comb begin
    if (det_r.d[DET_W-1]) begin
      norm_nxt.d  = -det_r.d;
      norm_nxt.ln = -det_r.ln;
      norm_nxt.mn = -det_r.mn;
    end else begin
      norm_nxt = det_r;
    end
  end

  // classify and seed the divider
  always_comb begin
    dz      = (norm_r.d == '0);
    in_rng  = !norm_r.ln[DET_W-1] && ($signed(norm_r.ln) <= $signed(norm_r.d))
           && !norm_r.mn[DET_W-1] && ($signed(norm_r.mn) <= $signed(norm_r.d));
    on_edge = (norm_r.ln == '0) || (norm_r.ln == norm_r.d)
           || (norm_r.mn == '0) || (norm_r.mn == norm_r.d);
    if (dz) begin
      div_nxt[0].kind = KIND_PARALLEL;
    end else if (in_rng) begin
      div_nxt[0].kind = on_edge ? KIND_TOUCH : KIND_CROSS;
    end else begin
      div_nxt[0].kind = KIND_NONE;
    end
    div_nxt[0].sat = !dz && in_rng && (norm_r.ln == norm_r.d);
    div_nxt[0].den = norm_r.d[MAG_W-1:0];
    div_nxt[0].rem = norm_r.ln[MAG_W-1:0];
    div_nxt[0].quo = '0;

    // restoring division, one quotient bit per stage
    for (int j = 1; j <= FRAC_BITS; j++) begin
      r2[j] = {div_r[j-1].rem, 1'b0};
      ge[j] = (r2[j] >= {1'b0, div_r[j-1].den});
      div_nxt[j].kind = div_r[j-1].kind;
      div_nxt[j].sat  = div_r[j-1].sat;
      div_nxt[j].den  = div_r[j-1].den;
      div_nxt[j].rem  = ge[j] ? MAG_W'(r2[j] - {1'b0, div_r[j-1].den})
                              : r2[j][MAG_W-1:0];
      div_nxt[j].quo  = {div_r[j-1].quo[FRAC_BITS-2:0], ge[j]};
    end
  end

  // result beat
  always_comb begin
    pos_ok   = (div_r[FRAC_BITS].kind == KIND_CROSS)
            || (div_r[FRAC_BITS].kind == KIND_TOUCH);
    kind_nxt = div_r[FRAC_BITS].kind;
    if (!pos_ok) begin
      pos_nxt = '0;
    end else if (div_r[FRAC_BITS].sat) begin
      pos_nxt = POS_ONE;
    end else begin
      pos_nxt = {1'b0, div_r[FRAC_BITS].quo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) begin
      diff_r <= diff_nxt;
    end
    if (rdy[ST_PROD]) begin
      prod_r <= prod_nxt;
    end
    if (rdy[ST_DET]) begin
      det_r <= det_nxt;
    end
    if (rdy[ST_NORM]) begin
      norm_r <= norm_nxt;
    end
    for (int j = 0; j <= FRAC_BITS; j++) begin
      if (rdy[ST_CLASS + j]) begin
        div_r[j] <= div_nxt[j];
      end
    end
    if (rdy[ST_OUT]) begin
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign out_valid    = vld_r[ST_OUT];
  assign out_kind     = kind_r;
  assign out_position = pos_r;

  a_pos_zero_off_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NONE || out_kind == KIND_PARALLEL)
      |-> out_position == '0)
    else $error("position set on a beat with no intersection");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= POS_ONE)
    else $error("position above one");

  a_sat_is_touch: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_CLASS] && div_r[0].sat |-> div_r[0].kind == KIND_TOUCH)
    else $error("full parameter not classed as touching");

  a_empty_tail_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST_OUT] |-> !in_stall)
    else $error("input stalled with an empty output stage");

endmodule

[verif/tb_segment_intersection_classifier_unit.sv]
import sic_pkg::*;

typedef logic signed [COORD_BITS-1:0] coord_t;

typedef struct packed {
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_end_x;
  coord_t second_end_y;
} seg_pair_t;

typedef struct {
  kind_t            kind;
  logic [POS_W-1:0] position;
} verdict_t;

class crossing_ledger;
  verdict_t due[$];
  int       mismatches;
  int       pairs_in;
  int       verdicts_out;
  int       kind_seen[4];

  function new();
    mismatches   = 0;
    pairs_in     = 0;
    verdicts_out = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
  endfunction

  function int pending();
    return due.size();
  endfunction

  // exact integer classification, no division until the position
  function verdict_t classify(seg_pair_t p);
    longint ax, ay, bx, by, cx, cy;
    longint det, lam_num, mu_num;
    verdict_t v;
    ax = longint'(p.first_end_x) - longint'(p.first_start_x);
    ay = longint'(p.first_end_y) - longint'(p.first_start_y);
    bx = longint'(p.second_end_x) - longint'(p.second_start_x);
    by = longint'(p.second_end_y) - longint'(p.second_start_y);
    cx = longint'(p.first_start_x) - longint'(p.second_start_x);
    cy = longint'(p.first_start_y) - longint'(p.second_start_y);
    det     = ax * by - ay * bx;
    lam_num = cy * bx - cx * by;
    mu_num  = cy * ax - cx * ay;
    v.kind     = KIND_PARALLEL;
    v.position = '0;
    if (det != 0) begin
      if (det < 0) begin
        det     = -det;
        lam_num = -lam_num;
        mu_num  = -mu_num;
      end
      if (lam_num >= 0 && lam_num <= det && mu_num >= 0 && mu_num <= det) begin
        if (lam_num == 0 || lam_num == det || mu_num == 0 || mu_num == det) begin
          v.kind = KIND_TOUCH;
        end else begin
          v.kind = KIND_CROSS;
        end
        v.position = POS_W'((lam_num <<< FRAC_BITS) / det);
      end else begin
        v.kind = KIND_NONE;
      end
    end
    return v;
  endfunction

  function void note_pair(seg_pair_t p);
    due.push_back(classify(p));
    pairs_in++;
  endfunction

  task flag_mismatch(string msg);
    mismatches++;
    $display("mismatch on result %0d: %s", verdicts_out, msg);
  endtask

  task check_verdict(logic [1:0] kind, logic [POS_W-1:0] position);
    verdict_t v;
    verdicts_out++;
    if (due.size() == 0) begin
      flag_mismatch("result beat with nothing outstanding");
    end else begin
      v = due.pop_front();
      kind_seen[v.kind]++;
      if (kind !== v.kind) begin
        flag_mismatch($sformatf("kind %0d, expected %s", kind, v.kind.name()));
      end
      if (position !== v.position) begin
        flag_mismatch($sformatf("position %0d, expected %0d", position, v.position));
      end
    end
  endtask
endclass

module tb_segment_intersection_classifier_unit;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PAIRS = 500;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  coord_t           in_first_start_x;
  coord_t           in_first_start_y;
  coord_t           in_first_end_x;
  coord_t           in_first_end_y;
  coord_t           in_second_start_x;
  coord_t           in_second_start_y;
  coord_t           in_second_end_x;
  coord_t           in_second_end_y;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_kind;
  logic [POS_W-1:0] out_position;

  crossing_ledger ledger;
  int cycle_count;
  int stall_left;
  int rx_phase_left;
  bit rx_calm;

  segment_intersection_classifier_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_start_x  (in_first_start_x),
    .in_first_start_y  (in_first_start_y),
    .in_first_end_x    (in_first_end_x),
    .in_first_end_y    (in_first_end_y),
    .in_second_start_x (in_second_start_x),
    .in_second_start_y (in_second_start_y),
    .in_second_end_x   (in_second_end_x),
    .in_second_end_y   (in_second_end_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_position      (out_position)
  );

  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t p;
    p.first_start_x  = coord_t'(a);
    p.first_start_y  = coord_t'(b);
    p.first_end_x    = coord_t'(c);
    p.first_end_y    = coord_t'(d);
    p.second_start_x = coord_t'(e);
    p.second_start_y = coord_t'(f);
    p.second_end_x   = coord_t'(g);
    p.second_end_y   = coord_t'(h);
    return p;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int reach();
    return ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 30);
  endfunction

  function automatic seg_pair_t random_pair();
    int r, px, py, ux, uy, vx, vy, a, b, c, e, m, ox, oy;
    r = $urandom_range(99);
    if (r < 35) begin
      return mk($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    end
    if (r < 55) begin
      return mk($urandom_range(16) - 8, $urandom_range(16) - 8,
                $urandom_range(16) - 8, $urandom_range(16) - 8,
                $urandom_range(16) - 8, $urandom_range(16) - 8,
                $urandom_range(16) - 8, $urandom_range(16) - 8);
    end
    if (r < 80) begin
      // both segments pass through one point, ends at chosen multiples
      px = $urandom_range(24000) - 12000;
      py = $urandom_range(24000) - 12000;
      ux = $urandom_range(600) - 300;
      uy = $urandom_range(600) - 300;
      vx = $urandom_range(600) - 300;
      vy = $urandom_range(600) - 300;
      a = reach();
      b = reach();
      c = reach();
      e = reach();
      return mk(px - a * ux, py - a * uy, px + b * ux, py + b * uy,
                px - c * vx, py - c * vy, px + e * vx, py + e * vy);
    end
    if (r < 90) begin
      // shared direction: colinear or offset
      px = $urandom_range(8000) - 4000;
      py = $urandom_range(8000) - 4000;
      ux = $urandom_range(200) - 100;
      uy = $urandom_range(200) - 100;
      a = $urandom_range(10);
      m = $urandom_range(20) - 10;
      ox = ($urandom_range(1) == 0) ? 0 : $urandom_range(100) - 50;
      oy = ($urandom_range(1) == 0) ? 0 : $urandom_range(100) - 50;
      return mk(px, py, px + 10 * ux, py + 10 * uy,
                px + a * ux + ox, py + a * uy + oy,
                px + (a + m) * ux + ox, py + (a + m) * uy + oy);
    end
    return mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
              pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
  endfunction

  task automatic send_pair(seg_pair_t p, int gap);
    in_valid          <= 1'b1;
    in_first_start_x  <= p.first_start_x;
    in_first_start_y  <= p.first_start_y;
    in_first_end_x    <= p.first_end_x;
    in_first_end_y    <= p.first_end_y;
    in_second_start_x <= p.second_start_x;
    in_second_start_y <= p.second_start_y;
    in_second_end_x   <= p.second_end_x;
    in_second_end_y   <= p.second_end_y;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_pair(p);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0), idle_len());
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), idle_len());
    send_pair(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767), idle_len());
    send_pair(mk(-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767), idle_len());
    send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1), idle_len());
    send_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), idle_len());
    // colinear overlap and parallel apart
    send_pair(mk(0, 0, 10, 0, 5, 0, 15, 0), idle_len());
    send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5), idle_len());
    // touching at either end of the first segment
    send_pair(mk(0, 0, 10, 0, 0, -5, 0, 5), idle_len());
    send_pair(mk(0, 0, 10, 0, 10, -5, 10, 5), idle_len());
    // touching at either end of the second segment
    send_pair(mk(0, 0, 10, 0, 5, 0, 5, 5), idle_len());
    send_pair(mk(0, 0, 10, 0, 5, 5, 5, 0), idle_len());
    send_pair(mk(0, 0, 10, 0, 10, 0, 10, 10), idle_len());
    // lines meet outside one of the segments
    send_pair(mk(0, 0, 10, 0, 20, -5, 20, 5), idle_len());
    send_pair(mk(0, 0, 10, 0, -3, -5, -3, 5), idle_len());
    send_pair(mk(0, 0, 10, 0, 5, 1, 5, 10), idle_len());
    // opposite determinant signs
    send_pair(mk(0, 0, 10, 10, 10, 0, 0, 10), idle_len());
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0), idle_len());
    // fraction that rounds down
    send_pair(mk(0, 0, 3, 0, 1, -1, 1, 1), idle_len());
    send_pair(mk(0, 0, 65535, 1, 1, -32768, 1, 32767), idle_len());
    // a point segment
    send_pair(mk(7, 7, 7, 7, 0, 0, 20, 20), idle_len());
    // tiny determinant, huge numerators
    send_pair(mk(-32768, 0, 32767, 1, -32768, 32767, 32767, 32767), 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      ledger.check_verdict(out_kind, out_position);
    end
    if (rx_phase_left == 0) begin
      rx_calm = ($urandom_range(3) == 0);
      rx_phase_left = $urandom_range(20, 200);
    end else begin
      rx_phase_left--;
    end
    if (rx_calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", ledger.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    out_stall         = 1'b0;
    in_first_start_x  = '0;
    in_first_start_y  = '0;
    in_first_end_x    = '0;
    in_first_end_y    = '0;
    in_second_start_x = '0;
    in_second_start_y = '0;
    in_second_end_x   = '0;
    in_second_end_y   = '0;
    cycle_count       = 0;
    stall_left        = 0;
    rx_phase_left     = 0;
    rx_calm           = 1'b0;
    ledger            = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain();
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 2) drain();
      send_pair(random_pair(), (i % 100 < 25) ? 0 : idle_len());
    end
    drain();
    repeat (40) @(posedge clk);
    $display("%0d segment pairs sent, %0d results checked", ledger.pairs_in,
             ledger.verdicts_out);
    $display("verdicts seen: %0d crossing, %0d touching, %0d parallel, %0d apart",
             ledger.kind_seen[KIND_CROSS], ledger.kind_seen[KIND_TOUCH],
             ledger.kind_seen[KIND_PARALLEL], ledger.kind_seen[KIND_NONE]);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
